// File: rtl/gml_pkg.sv
// Package: shared types, constants and codes of the glyph metrics loader.
package gml_pkg;

	localparam int unsigned MAX_GLYPHS_DEF = 1024;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_WORD   = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	localparam logic [2:0] ST_TAKEN    = 3'd0;
	localparam logic [2:0] ST_LOADED   = 3'd1;
	localparam logic [2:0] ST_FOUND    = 3'd2;
	localparam logic [2:0] ST_MISSING  = 3'd3;
	localparam logic [2:0] ST_IGNORED  = 3'd4;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_RECORDS = 2'd2;
	localparam logic [1:0] PH_LOADED  = 2'd3;

	localparam logic [7:0] CODE_SPACE = 8'h20;
	localparam logic [7:0] CODE_NBSP  = 8'hA0;
	localparam logic [31:0] HDR_BYTES = 32'd24;
	localparam logic [31:0] REC_BYTES = 32'd28;

	// metrics entry: height, width, advance, dy, dx from bit 0 up
	localparam int unsigned MET_W = 48;

	typedef struct packed {
		logic       word_go;
		logic       scan_start;
		logic       scan_step;
		logic       out_load;
		logic [1:0] out_kind;
	} ctrl_t;

	localparam logic [1:0] OK_WORD = 2'd0;
	localparam logic [1:0] OK_FOUND = 2'd1;
	localparam logic [1:0] OK_MISS = 2'd2;

	typedef struct packed {
		logic scan_last;
		logic scan_hit;
		logic scan_empty;
	} stat_t;

endpackage

// File: rtl/gml_ram.sv
// Generic single-port-write, registered-read RAM.
module gml_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/gml_ctrl.sv
// Controller: sequences file words and table scans for lookups.
module gml_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic [1:0]    in_mode,
	input  logic          out_free,
	input  gml_pkg::stat_t stat,
	output gml_pkg::ctrl_t ctrl,
	output logic          busy
);
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_CHECK = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= gml_pkg::OK_WORD;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && in_mode == gml_pkg::MODE_LOOKUP) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (stat.scan_empty) begin
						kind_q <= gml_pkg::OK_MISS;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.scan_hit) begin
						kind_q <= gml_pkg::OK_FOUND;
						state_q <= S_EMIT;
					end else if (stat.scan_last) begin
						kind_q <= gml_pkg::OK_MISS;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctrl = '0;
		ctrl.word_go = (state_q == S_IDLE) && in_fire && in_mode != gml_pkg::MODE_LOOKUP;
		ctrl.scan_start = (state_q == S_IDLE) && in_fire && in_mode == gml_pkg::MODE_LOOKUP;
		ctrl.scan_step = (state_q == S_CHECK) && !stat.scan_hit && !stat.scan_last;
		ctrl.out_load = ctrl.word_go || ((state_q == S_EMIT) && out_free);
		ctrl.out_kind = ctrl.word_go ? gml_pkg::OK_WORD : kind_q;
	end

	assign busy = (state_q != S_IDLE);
endmodule

// File: rtl/gml_dp.sv
// Datapath: header and record parsing, metrics, tables, scan and result register.
module gml_dp #(
	parameter int unsigned MAX_GLYPHS = gml_pkg::MAX_GLYPHS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  gml_pkg::ctrl_t ctrl,
	output gml_pkg::stat_t stat,
	input  logic [1:0]     in_mode,
	input  logic [31:0]    in_word,
	input  logic [15:0]    in_query,
	input  logic           out_take,
	output logic           out_valid,
	output logic [2:0]     status,
	output logic [9:0]     glyph_index,
	output logic [7:0]     glyph_height,
	output logic [7:0]     glyph_width,
	output logic [7:0]     cursor_advance,
	output logic [15:0]    top_offset,
	output logic [7:0]     left_offset,
	output logic [31:0]    bitmap_offset,
	output logic [15:0]    max_ascent_out,
	output logic [15:0]    max_descent_out,
	output logic [15:0]    line_advance_out,
	output logic [15:0]    space_width_out
);
	localparam int unsigned AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam logic [16:0] CAP = 17'(MAX_GLYPHS);

	logic [2:0]  hpos_q, rpos_q;
	logic [15:0] expected_q, seen_q, points_q, asc_q, desc_q, line_q, space_q;
	logic [31:0] boff_q;
	logic [63:0] pend_q;
	logic [1:0]  phase_q;

	logic [15:0] query_q;
	logic [16:0] idx_q, stored_q;

	logic [2:0]  st_n;
	logic        commit;
	logic [15:0] g_code;
	logic [7:0]  g_h, g_w, g_adv, g_dx;
	logic signed [16:0] g_dy, dy_cl, g_desc;
	logic        usable;
	logic [15:0] asc_n, desc_n;
	logic [15:0] asc_nx, desc_nx, line_nx, space_nx;

	logic [15:0]        code_rd;
	logic [gml_pkg::MET_W-1:0] met_rd;
	logic [31:0]        off_rd;
	logic               we;

	assign g_code = pend_q[15:0];
	assign g_h = pend_q[23:16];
	assign g_w = pend_q[31:24];
	assign g_adv = pend_q[39:32];
	assign g_dy = 17'(signed'(pend_q[55:40]));
	assign g_dx = pend_q[63:56];
	assign usable = (g_code > 16'(gml_pkg::CODE_SPACE)) && (g_code != 16'(gml_pkg::CODE_NBSP));
	assign dy_cl = (g_dy > signed'({1'b0, points_q})) ? signed'({1'b0, points_q}) : g_dy;
	assign g_desc = signed'({9'd0, g_h}) - dy_cl;
	assign asc_n = (usable && g_dy > signed'({1'b0, asc_q})) ? g_dy[15:0] : asc_q;
	assign desc_n = (usable && g_desc > signed'({1'b0, desc_q})) ? g_desc[15:0] : desc_q;
	assign commit = ctrl.word_go && in_mode == gml_pkg::MODE_WORD
		&& phase_q == gml_pkg::PH_RECORDS && rpos_q == 3'd6;
	assign we = commit && ({1'b0, seen_q} < CAP);

	always_comb begin
		st_n = gml_pkg::ST_TAKEN;
		if (in_mode == gml_pkg::MODE_WORD) begin
			if (phase_q == gml_pkg::PH_HEADER) begin
				if (hpos_q == 3'd5 && expected_q == '0) st_n = gml_pkg::ST_LOADED;
			end else if (phase_q == gml_pkg::PH_RECORDS) begin
				if (rpos_q == 3'd6 && seen_q + 16'd1 == expected_q) st_n = gml_pkg::ST_LOADED;
			end else begin
				st_n = gml_pkg::ST_IGNORED;
			end
		end else if (in_mode != gml_pkg::MODE_START) begin
			st_n = gml_pkg::ST_IGNORED;
		end
	end

	always_comb begin
		asc_nx = asc_q;
		desc_nx = desc_q;
		line_nx = line_q;
		space_nx = space_q;
		if (ctrl.word_go) begin
			if (in_mode == gml_pkg::MODE_START) begin
				asc_nx = '0;
				desc_nx = '0;
				line_nx = '0;
				space_nx = '0;
			end else if (in_mode == gml_pkg::MODE_WORD) begin
				if (phase_q == gml_pkg::PH_HEADER) begin
					if (hpos_q == 3'd4) begin
						asc_nx = in_word[15:0];
					end else if (hpos_q == 3'd5) begin
						desc_nx = in_word[15:0];
						line_nx = asc_q + in_word[15:0];
						space_nx = line_nx >> 2;
					end
				end else if (phase_q == gml_pkg::PH_RECORDS && rpos_q == 3'd6) begin
					asc_nx = asc_n;
					desc_nx = desc_n;
					line_nx = asc_n + desc_n;
					if (g_code == 16'(gml_pkg::CODE_SPACE)) space_nx = 16'(g_adv);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpos_q <= '0; rpos_q <= '0; expected_q <= '0; seen_q <= '0;
			points_q <= '0; asc_q <= '0; desc_q <= '0; line_q <= '0;
			space_q <= '0; boff_q <= '0; pend_q <= '0;
			phase_q <= gml_pkg::PH_IDLE;
		end else if (ctrl.word_go) begin
			if (in_mode == gml_pkg::MODE_START) begin
				expected_q <= in_word[15:0];
				seen_q <= '0; rpos_q <= '0; pend_q <= '0; points_q <= '0;
				asc_q <= '0; desc_q <= '0; line_q <= '0; space_q <= '0;
				boff_q <= '0; hpos_q <= 3'd1;
				phase_q <= gml_pkg::PH_HEADER;
			end else if (in_mode == gml_pkg::MODE_WORD) begin
				if (phase_q == gml_pkg::PH_HEADER) begin
					hpos_q <= hpos_q + 3'd1;
					case (hpos_q)
						3'd2: points_q <= in_word[15:0];
						3'd4: asc_q <= in_word[15:0];
						3'd5: begin
							desc_q <= in_word[15:0];
							line_q <= asc_q + in_word[15:0];
							space_q <= 16'((asc_q + in_word[15:0]) >> 2);
							boff_q <= gml_pkg::HDR_BYTES + 32'(expected_q) * gml_pkg::REC_BYTES;
							rpos_q <= '0;
							seen_q <= '0;
							phase_q <= (expected_q == '0) ? gml_pkg::PH_LOADED
								: gml_pkg::PH_RECORDS;
						end
						default: ;
					endcase
				end else if (phase_q == gml_pkg::PH_RECORDS) begin
					rpos_q <= (rpos_q >= 3'd6) ? 3'd0 : rpos_q + 3'd1;
					case (rpos_q)
						3'd0: pend_q <= {48'd0, in_word[15:0]};
						3'd1: pend_q[23:16] <= in_word[7:0];
						3'd2: pend_q[31:24] <= in_word[7:0];
						3'd3: pend_q[39:32] <= in_word[7:0];
						3'd4: pend_q[55:40] <= in_word[15:0];
						3'd5: pend_q[63:56] <= in_word[7:0];
						default: begin
							if (g_code == 16'(gml_pkg::CODE_SPACE)) space_q <= 16'(g_adv);
							asc_q <= asc_n;
							desc_q <= desc_n;
							line_q <= asc_n + desc_n;
							boff_q <= boff_q + 32'(g_w) * 32'(g_h);
							seen_q <= seen_q + 16'd1;
							if (seen_q + 16'd1 == expected_q) phase_q <= gml_pkg::PH_LOADED;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			stored_q <= '0;
			query_q <= '0;
		end else if (ctrl.scan_start) begin
			idx_q <= '0;
			query_q <= in_query;
			stored_q <= ({1'b0, seen_q} < CAP) ? {1'b0, seen_q} : CAP;
		end else if (ctrl.scan_step) begin
			idx_q <= idx_q + 17'd1;
		end
	end

	logic [AW-1:0] raddr;
	assign raddr = ctrl.scan_step ? AW'(idx_q + 17'd1) : AW'(idx_q);

	assign stat.scan_empty = (stored_q == '0);
	assign stat.scan_hit = (code_rd == query_q);
	assign stat.scan_last = (idx_q + 17'd1 >= stored_q);

	gml_ram #(.WIDTH(16), .DEPTH(MAX_GLYPHS)) u_code (
		.clk(clk), .we(we), .waddr(AW'(seen_q)), .wdata(g_code),
		.raddr(raddr), .rdata(code_rd));
	gml_ram #(.WIDTH(gml_pkg::MET_W), .DEPTH(MAX_GLYPHS)) u_met (
		.clk(clk), .we(we), .waddr(AW'(seen_q)),
		.wdata({g_dx, dy_cl[15:0], g_adv, g_w, g_h}),
		.raddr(raddr), .rdata(met_rd));
	gml_ram #(.WIDTH(32), .DEPTH(MAX_GLYPHS)) u_off (
		.clk(clk), .we(we), .waddr(AW'(seen_q)), .wdata(boff_q),
		.raddr(raddr), .rdata(off_rd));

	logic found;
	assign found = (ctrl.out_kind == gml_pkg::OK_FOUND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid <= 1'b1;
		end else if (out_take) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			case (ctrl.out_kind)
				gml_pkg::OK_FOUND: status <= gml_pkg::ST_FOUND;
				gml_pkg::OK_MISS: status <= gml_pkg::ST_MISSING;
				default: status <= st_n;
			endcase
			glyph_index <= found ? idx_q[9:0] : '0;
			glyph_height <= found ? met_rd[7:0] : '0;
			glyph_width <= found ? met_rd[15:8] : '0;
			cursor_advance <= found ? met_rd[23:16] : '0;
			top_offset <= found ? met_rd[39:24] : '0;
			left_offset <= found ? met_rd[47:40] : '0;
			bitmap_offset <= found ? off_rd : '0;
			max_ascent_out <= asc_nx;
			max_descent_out <= desc_nx;
			line_advance_out <= line_nx;
			space_width_out <= space_nx;
		end
	end
endmodule

// File: rtl/glyph_metrics_loader_lookup.sv
// Top level of the glyph metrics loader and lookup.
// Usage: each input transaction carries a mode in tuser and a file word
// and query code in tdata. Mode 0 starts a font load with the glyph count,
// mode 1 feeds the next big-endian file word, mode 2 looks up a code.
// Every input transaction yields exactly one output transaction with a
// status and the running metrics; found glyph fields are zero otherwise.
// A file word's result is registered in its acceptance cycle and is valid in
// the next; the next item is taken in the cycle after that result is loaded,
// once the output is free. A lookup reads the code table through one RAM
// port, one entry per cycle, and ends at the first hit or as a miss after the
// last of n stored glyphs (n up to MAX_GLYPHS).
// Reset clears the load state; table contents stay undefined until loaded.
// The output register holds its transaction while m_axis_tready is low; the
// block takes no new input until the pending result is taken.
module glyph_metrics_loader_lookup #(
	parameter int unsigned MAX_GLYPHS = gml_pkg::MAX_GLYPHS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// file_word[31:0], query_code[47:32]
	input  logic [47:0]  s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// glyph_index[9:0], glyph_height[17:10], glyph_width[25:18],
	// cursor_advance[33:26], top_offset[49:34], left_offset[57:50],
	// bitmap_offset[89:58], max_ascent_out[105:90], max_descent_out[121:106],
	// line_advance_out[137:122], space_width_out[153:138], zero fill up
	output logic [159:0] m_axis_tdata,
	// status[2:0]
	output logic [2:0]   m_axis_tuser
);
	gml_pkg::ctrl_t ctrl;
	gml_pkg::stat_t stat;
	logic busy, in_fire, out_free;
	logic [2:0] status;
	logic [9:0] glyph_index;
	logic [7:0] glyph_height, glyph_width, cursor_advance, left_offset;
	logic [15:0] top_offset, max_a, max_d, line_a, space_w;
	logic [31:0] bitmap_offset;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !busy && out_free;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	gml_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_mode(s_axis_tuser),
		.out_free(out_free), .stat(stat), .ctrl(ctrl), .busy(busy));

	gml_dp #(.MAX_GLYPHS(MAX_GLYPHS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.in_mode(s_axis_tuser), .in_word(s_axis_tdata[31:0]),
		.in_query(s_axis_tdata[47:32]), .out_take(m_axis_tready),
		.out_valid(m_axis_tvalid), .status(status), .glyph_index(glyph_index),
		.glyph_height(glyph_height), .glyph_width(glyph_width),
		.cursor_advance(cursor_advance), .top_offset(top_offset),
		.left_offset(left_offset), .bitmap_offset(bitmap_offset),
		.max_ascent_out(max_a), .max_descent_out(max_d),
		.line_advance_out(line_a), .space_width_out(space_w));

	assign m_axis_tuser = status;
	assign m_axis_tdata = {6'd0, space_w, line_a, max_d, max_a, bitmap_offset,
		left_offset, top_offset, cursor_advance, glyph_width, glyph_height,
		glyph_index};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("input taken during scan");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_axis_tuser != gml_pkg::MODE_LOOKUP) |=> m_axis_tvalid)
		else $error("word result missing");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= gml_pkg::ST_IGNORED))
		else $error("bad status");
endmodule

// File: sim/tb.sv
// Testbench of the glyph metrics loader: streams font files and lookups, checks each result.
module tb;
	localparam int TABLE_SIZE = 1024;
	localparam int ERR_SHOW = 10;

	typedef struct packed {
		logic [5:0]  pad;
		logic [15:0] space_w;
		logic [15:0] line_adv;
		logic [15:0] max_desc;
		logic [15:0] max_asc;
		logic [31:0] bmp_ofs;
		logic [7:0]  left_ofs;
		logic [15:0] top_ofs;
		logic [7:0]  advance;
		logic [7:0]  width;
		logic [7:0]  height;
		logic [9:0]  index;
	} glyph_result_t;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] word;
		logic [15:0] query;
		bit          drain;
	} font_item_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [159:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;

	glyph_metrics_loader_lookup dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #10 clk = ~clk;

	font_item_t pending_items[$];
	glyph_result_t expected_results[$];
	logic [2:0] expected_status[$];
	int errors = 0;
	int accepted = 0;
	int hold_cycles = 0;
	bit hold_done = 0;
	bit in_taken = 0;

	// loader state
	logic [2:0]  hdr_pos, rec_pos;
	logic [1:0]  phase;
	logic [15:0] glyph_count, glyphs_done, font_size, asc_max, desc_max, line_h, space_adv;
	logic [31:0] bmp_next;
	logic [63:0] rec_buf;
	logic [15:0] codes [TABLE_SIZE];
	logic [47:0] metrics [TABLE_SIZE];
	logic [31:0] offsets [TABLE_SIZE];

	task automatic store_glyph(output logic [2:0] st);
		logic [15:0] code;
		logic [7:0] h, w, adv, dx;
		int dy, dsc;
		bit usable;
		st = gml_pkg::ST_TAKEN;
		code = rec_buf[15:0];
		h = rec_buf[23:16];
		w = rec_buf[31:24];
		adv = rec_buf[39:32];
		dy = $signed(rec_buf[55:40]);
		dx = rec_buf[63:56];
		usable = code > 16'(gml_pkg::CODE_SPACE) && code != 16'(gml_pkg::CODE_NBSP);
		if (code == 16'(gml_pkg::CODE_SPACE)) space_adv = 16'(adv);
		if (dy > int'(asc_max) && usable) asc_max = dy[15:0];
		if (dy > int'(font_size)) dy = int'(font_size);
		dsc = int'(h) - dy;
		if (dsc > int'(desc_max) && usable) desc_max = dsc[15:0];
		line_h = asc_max + desc_max;
		if (glyphs_done < TABLE_SIZE) begin
			codes[glyphs_done] = code;
			metrics[glyphs_done] = {dx, dy[15:0], adv, w, h};
			offsets[glyphs_done] = bmp_next;
		end
		bmp_next = bmp_next + 32'(w) * 32'(h);
		glyphs_done = glyphs_done + 16'd1;
		if (glyphs_done == glyph_count) begin
			phase = gml_pkg::PH_LOADED;
			st = gml_pkg::ST_LOADED;
		end
	endtask

	task automatic predict_result(input font_item_t it, output logic [2:0] st,
		output glyph_result_t r);
		int n;
		r = '0;
		st = gml_pkg::ST_TAKEN;
		if (it.mode == gml_pkg::MODE_START) begin
			glyph_count = it.word[15:0];
			glyphs_done = 0; rec_pos = 0; rec_buf = 0; font_size = 0;
			asc_max = 0; desc_max = 0; line_h = 0; space_adv = 0; bmp_next = 0;
			hdr_pos = 1;
			phase = gml_pkg::PH_HEADER;
		end else if (it.mode == gml_pkg::MODE_WORD) begin
			if (phase == gml_pkg::PH_HEADER) begin
				case (hdr_pos)
					3'd2: font_size = it.word[15:0];
					3'd4: asc_max = it.word[15:0];
					3'd5: begin
						desc_max = it.word[15:0];
						line_h = asc_max + desc_max;
						space_adv = line_h / 4;
						bmp_next = gml_pkg::HDR_BYTES + 32'(glyph_count) * gml_pkg::REC_BYTES;
						rec_pos = 0;
						glyphs_done = 0;
						if (glyph_count == 0) begin
							phase = gml_pkg::PH_LOADED;
							st = gml_pkg::ST_LOADED;
						end else
							phase = gml_pkg::PH_RECORDS;
					end
					default: ;
				endcase
				hdr_pos = hdr_pos + 3'd1;
			end else if (phase == gml_pkg::PH_RECORDS) begin
				case (rec_pos)
					3'd0: rec_buf = {48'd0, it.word[15:0]};
					3'd1: rec_buf[23:16] = it.word[7:0];
					3'd2: rec_buf[31:24] = it.word[7:0];
					3'd3: rec_buf[39:32] = it.word[7:0];
					3'd4: rec_buf[55:40] = it.word[15:0];
					3'd5: rec_buf[63:56] = it.word[7:0];
					default: store_glyph(st);
				endcase
				rec_pos = (rec_pos >= 3'd6) ? 3'd0 : rec_pos + 3'd1;
			end else
				st = gml_pkg::ST_IGNORED;
		end else if (it.mode == gml_pkg::MODE_LOOKUP) begin
			n = glyphs_done < TABLE_SIZE ? glyphs_done : TABLE_SIZE;
			st = gml_pkg::ST_MISSING;
			for (int i = 0; i < n; i++) begin
				if (codes[i] == it.query) begin
					st = gml_pkg::ST_FOUND;
					r.index = i[9:0];
					{r.left_ofs, r.top_ofs, r.advance, r.width, r.height} = metrics[i];
					r.bmp_ofs = offsets[i];
					break;
				end
			end
		end else
			st = gml_pkg::ST_IGNORED;
		r.max_asc = asc_max;
		r.max_desc = desc_max;
		r.line_adv = line_h;
		r.space_w = space_adv;
	endtask

	task automatic push(input logic [1:0] md, input logic [31:0] wd, input logic [15:0] q = 0,
		input bit drain = 0);
		font_item_t it;
		it.mode = md; it.word = wd; it.query = q; it.drain = drain;
		pending_items.push_back(it);
	endtask

	task automatic push_header(input int n, input logic [15:0] sz, input logic [15:0] asc,
		input logic [15:0] dsc);
		push(gml_pkg::MODE_START, {16'($urandom), 16'(n)});
		push(gml_pkg::MODE_WORD, $urandom);
		push(gml_pkg::MODE_WORD, {16'($urandom), sz});
		push(gml_pkg::MODE_WORD, $urandom);
		push(gml_pkg::MODE_WORD, {16'($urandom), asc});
		push(gml_pkg::MODE_WORD, {16'($urandom), dsc});
	endtask

	task automatic push_glyph(input logic [15:0] code, input logic [7:0] h, input logic [7:0] w,
		input logic [7:0] adv, input logic [15:0] dy, input logic [7:0] dx);
		push(gml_pkg::MODE_WORD, {16'($urandom), code});
		push(gml_pkg::MODE_WORD, {24'($urandom), h});
		push(gml_pkg::MODE_WORD, {24'($urandom), w});
		push(gml_pkg::MODE_WORD, {24'($urandom), adv});
		push(gml_pkg::MODE_WORD, {16'($urandom), dy});
		push(gml_pkg::MODE_WORD, {24'($urandom), dx});
		push(gml_pkg::MODE_WORD, $urandom);
	endtask

	function automatic logic [15:0] pick_code();
		case ($urandom_range(5))
			0: return 16'(gml_pkg::CODE_SPACE);
			1: return 16'(gml_pkg::CODE_NBSP);
			2: return 16'($urandom);
			default: return 16'($urandom_range(16'h10, 16'h48));
		endcase
	endfunction

	task automatic push_random_font(input int n);
		push_header(n, $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(40)),
			16'($urandom_range(30)), 16'($urandom_range(12)));
		for (int g = 0; g < n; g++) begin
			push_glyph(pick_code(), 8'($urandom), 8'($urandom), 8'($urandom),
				$urandom_range(3) == 0 ? 16'($urandom) : 16'($signed($urandom_range(60)) - 10),
				8'($urandom));
			if ($urandom_range(15) == 0) push(gml_pkg::MODE_LOOKUP, $urandom, pick_code());
		end
	endtask

	initial begin
		hdr_pos = '0; rec_pos = '0; phase = gml_pkg::PH_IDLE;
		glyph_count = '0; glyphs_done = '0; font_size = '0; asc_max = '0;
		desc_max = '0; line_h = '0; space_adv = '0; bmp_next = '0; rec_buf = '0;
		push(gml_pkg::MODE_WORD, 32'h1234_5678);
		push(gml_pkg::MODE_LOOKUP, 0, 16'h0041);
		push_header(5, 16'd20, 16'hFFFF, 16'h0003);
		push_glyph(16'h0041, 8'hFF, 8'hFF, 8'hFF, 16'h7FFF, 8'h80);
		push(gml_pkg::MODE_LOOKUP, 0, 16'h0041);
		push_glyph(16'h0020, 8'h00, 8'h00, 8'h07, 16'h8000, 8'h7F);
		push_glyph(16'h00A0, 8'h10, 8'h02, 8'h01, 16'h0005, 8'hFF);
		push_glyph(16'h0010, 8'h01, 8'h01, 8'h00, 16'hFFFE, 8'h00);
		push_glyph(16'hFFFF, 8'h30, 8'h04, 8'h09, 16'h0015, 8'h01);
		push(gml_pkg::MODE_WORD, 32'hFFFF_FFFF);
		push(2'd3, 32'hFFFF_FFFF, 16'hFFFF);
		push(gml_pkg::MODE_LOOKUP, 0, 16'hFFFF);
		push(gml_pkg::MODE_LOOKUP, 0, 16'h0000);
		push_header(0, 16'd0, 16'd0, 16'd0);
		push(gml_pkg::MODE_LOOKUP, 0, 16'h0041);
		while (pending_items.size() < 580) begin
			if ($urandom_range(9) == 0) begin
				push($urandom_range(3) == 0 ? 2'd3 : gml_pkg::MODE_WORD, $urandom,
					16'($urandom));
				if ($urandom_range(1)) push(gml_pkg::MODE_START, $urandom_range(4));
			end else begin
				push_random_font($urandom_range(1, 8));
				repeat ($urandom_range(2, 6)) push(gml_pkg::MODE_LOOKUP, 0, pick_code());
			end
		end
		push(gml_pkg::MODE_LOOKUP, 0, 16'h0041, 1);
		push(gml_pkg::MODE_LOOKUP, 0, pick_code());
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1;
	end

	always @(negedge clk) begin
		if (!s_axis_tvalid || in_taken) begin
			in_taken = 0;
			if (arst_n && pending_items.size() > 0
				&& !(pending_items[0].drain && expected_results.size() > 0)
				&& !((accepted < 250 || accepted > 450) && $urandom_range(99) < 10)) begin
				s_axis_tvalid <= 1;
				s_axis_tuser <= pending_items[0].mode;
				s_axis_tdata <= {pending_items[0].query, pending_items[0].word};
				void'(pending_items.pop_front());
			end else
				s_axis_tvalid <= 0;
		end
	end

	always @(negedge clk) begin
		if (!hold_done && accepted >= 150) begin
			hold_done = 1;
			hold_cycles = 300;
		end
		if (hold_cycles > 0) hold_cycles--;
		m_axis_tready <= arst_n && hold_cycles == 0
			&& !((accepted < 250 || accepted > 450) && $urandom_range(99) < 10);
	end

	always @(posedge clk) begin
		font_item_t it;
		glyph_result_t exp_r, got;
		logic [2:0] exp_st;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_taken = 1;
				it.mode = s_axis_tuser;
				it.word = s_axis_tdata[31:0];
				it.query = s_axis_tdata[47:32];
				predict_result(it, exp_st, exp_r);
				expected_results.push_back(exp_r);
				expected_status.push_back(exp_st);
				accepted++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= ERR_SHOW) $display("unexpected transaction %p", got);
				end else begin
					exp_r = expected_results.pop_front();
					exp_st = expected_status.pop_front();
					if (got.index !== exp_r.index || got.height !== exp_r.height
						|| got.width !== exp_r.width || got.advance !== exp_r.advance
						|| got.top_ofs !== exp_r.top_ofs || got.left_ofs !== exp_r.left_ofs
						|| got.bmp_ofs !== exp_r.bmp_ofs || got.max_asc !== exp_r.max_asc
						|| got.max_desc !== exp_r.max_desc || got.line_adv !== exp_r.line_adv
						|| got.space_w !== exp_r.space_w || got.pad !== 6'd0
						|| m_axis_tuser !== exp_st) begin
						errors++;
						if (errors <= ERR_SHOW)
							$display("mismatch: status exp %0d got %0d\n exp %p\n got %p",
								exp_st, m_axis_tuser, exp_r, got);
					end
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		wait (pending_items.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
		repeat (1100) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
